>>> design/lsdrs_pkg.sv
// ----------------------------------------------------------------------------
// lsdrs_pkg
// Constants for the LSD radix sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lsdrs_pkg;

  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] DIGIT_BITS_RST = 4'd8;

endpackage : lsdrs_pkg

`default_nettype wire

>>> design/lsd_radix_sort_engine_top.sv
// ----------------------------------------------------------------------------
// lsd_radix_sort_engine_top
// Loads up to MAX_ITEMS non-negative words, sorts them with stable LSD
// counting-sort passes of 2^digit_bits radix, then streams them out ascending.
// ----------------------------------------------------------------------------
// Words are taken one per cycle on the in_ stream; the word with in_tlast set
// closes the set (words beyond MAX_ITEMS are dropped) and starts the sort, and
// in_tready stays low until the last sorted word has left on the out_ stream.
// Each pass over n words clears the histogram, counts the digits, forms the
// prefix sum, scatters the words and ends with a check; passes repeat until
// the largest word has no digits left. Unloading reads each word and holds it
// on the out_ stream until out_tready takes it. The steps work in turn on the
// one histogram memory and the one shared shifter that extracts digits.
// digit_bits is written through cfg_wen/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce. 0
// acts as 1 and values above MAX_DIGIT_BITS act as MAX_DIGIT_BITS.
`default_nettype none

module lsd_radix_sort_engine_top
  import lsdrs_pkg::*;
#(
  parameter int MAX_ITEMS      = 64,
  parameter int MAX_DIGIT_BITS = 8,
  parameter int VALUE_BITS     = 31,
  localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // value
  input  wire logic               in_tlast,   // last
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [TDATA_W-1:0] out_tdata,  // sorted_value
  output logic                    out_tlast,  // last_res
  input  wire logic               cfg_wen,
  input  wire logic [CFG_W-1:0]   cfg_wdata   // digit_bits
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int HA = MAX_DIGIT_BITS;
  localparam int HD = 1 << MAX_DIGIT_BITS;
  localparam int BB = $clog2(MAX_DIGIT_BITS + 1);
  localparam int SW = $clog2(VALUE_BITS + MAX_DIGIT_BITS + 1);

  typedef enum logic [3:0] {
    ST_LOAD, ST_CHECK, ST_CLR, ST_HRD, ST_HDG, ST_HWR, ST_PFX, ST_PTL,
    ST_SRD, ST_SDG, ST_SWR, ST_ORD, ST_OLD, ST_OWT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        dbits_r, dbits_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0]   max_r, max_nxt;
  logic [SW-1:0]           shift_r, shift_nxt;
  logic                    src_r, src_nxt;
  logic [CW-1:0]           i_r, i_nxt;
  logic [HA-1:0]           hidx_r, hidx_nxt;
  logic [HA-1:0]           pidx_r, pidx_nxt;
  logic                    pv_r, pv_nxt;
  logic [CW-1:0]           acc_r, acc_nxt;
  logic [HA-1:0]           digit_r, digit_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]   out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0]   dbuf_a [MAX_ITEMS];
  logic [VALUE_BITS-1:0]   dbuf_b [MAX_ITEMS];
  logic [CW-1:0]           hist   [HD];
  logic [VALUE_BITS-1:0]   dbuf_a_q, dbuf_b_q, dbuf_q;
  logic [CW-1:0]           hist_q;

  logic                    dbuf_we, dbuf_wsel;
  logic [AW-1:0]           dbuf_waddr, dbuf_raddr;
  logic [VALUE_BITS-1:0]   dbuf_wdata;
  logic                    hist_we;
  logic [HA-1:0]           hist_waddr, hist_raddr;
  logic [CW-1:0]           hist_wdata;

  logic [BB-1:0]           bits_eff;
  logic [HA-1:0]           dmask;
  logic [VALUE_BITS-1:0]   sh_in, sh_out;
  logic [HA-1:0]           digit;
  logic [CW-1:0]           acc_sum, cnt_m1, pos;
  logic [VALUE_BITS-1:0]   in_value;
  logic                    in_acc;

  assign in_value = in_tdata[VALUE_BITS-1:0];
  assign in_tready = (state_r == ST_LOAD);
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = TDATA_W'(out_data_r);
  assign out_tlast = out_last_r;

  always_comb begin
    if (dbits_r == '0) begin
      bits_eff = BB'(1);
    end else if (int'(dbits_r) > MAX_DIGIT_BITS) begin
      bits_eff = BB'(MAX_DIGIT_BITS);
    end else begin
      bits_eff = BB'(dbits_r);
    end
  end

  assign dmask  = ~({HA{1'b1}} << bits_eff);
  assign dbuf_q = src_r ? dbuf_b_q : dbuf_a_q;
  assign sh_in  = (state_r == ST_CHECK) ? max_r : dbuf_q;
  assign sh_out = sh_in >> shift_r;
  assign digit  = HA'(sh_out) & dmask;
  assign acc_sum = acc_r + hist_q;
  assign cnt_m1  = cnt_r - CW'(1);
  assign pos     = hist_q - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    dbits_nxt     = cfg_wen ? cfg_wdata : dbits_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    shift_nxt     = shift_r;
    src_nxt       = src_r;
    i_nxt         = i_r;
    hidx_nxt      = hidx_r;
    pidx_nxt      = pidx_r;
    pv_nxt        = pv_r;
    acc_nxt       = acc_r;
    digit_nxt     = digit_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    dbuf_we       = 1'b0;
    dbuf_wsel     = src_r;
    dbuf_waddr    = cnt_r[AW-1:0];
    dbuf_wdata    = in_value;
    dbuf_raddr    = i_r[AW-1:0];
    hist_we       = 1'b0;
    hist_waddr    = hidx_r;
    hist_wdata    = '0;
    hist_raddr    = hidx_r;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            dbuf_we = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            if (in_value > max_r) begin
              max_nxt = in_value;
            end
          end
          if (in_tlast) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        i_nxt = '0;
        hidx_nxt = '0;
        state_nxt = (sh_out != '0) ? ST_CLR : ST_ORD;
      end
      ST_CLR: begin
        hist_we = 1'b1;
        if (hidx_r == dmask) begin
          state_nxt = ST_HRD;
        end else begin
          hidx_nxt = hidx_r + HA'(1);
        end
      end
      ST_HRD: begin
        state_nxt = ST_HDG;
      end
      ST_HDG: begin
        hist_raddr = digit;
        digit_nxt = digit;
        state_nxt = ST_HWR;
      end
      ST_HWR: begin
        hist_we = 1'b1;
        hist_waddr = digit_r;
        hist_wdata = hist_q + CW'(1);
        if (i_r == cnt_m1) begin
          hidx_nxt = '0;
          pv_nxt = 1'b0;
          acc_nxt = '0;
          state_nxt = ST_PFX;
        end else begin
          i_nxt = i_r + CW'(1);
          state_nxt = ST_HRD;
        end
      end
      ST_PFX: begin
        if (pv_r) begin
          hist_we = 1'b1;
          hist_waddr = pidx_r;
          hist_wdata = acc_sum;
          acc_nxt = acc_sum;
        end
        pidx_nxt = hidx_r;
        pv_nxt = 1'b1;
        if (hidx_r == dmask) begin
          state_nxt = ST_PTL;
        end else begin
          hidx_nxt = hidx_r + HA'(1);
        end
      end
      ST_PTL: begin
        hist_we = 1'b1;
        hist_waddr = pidx_r;
        hist_wdata = acc_sum;
        i_nxt = cnt_m1;
        state_nxt = ST_SRD;
      end
      ST_SRD: begin
        state_nxt = ST_SDG;
      end
      ST_SDG: begin
        hist_raddr = digit;
        digit_nxt = digit;
        val_nxt = dbuf_q;
        state_nxt = ST_SWR;
      end
      ST_SWR: begin
        hist_we = 1'b1;
        hist_waddr = digit_r;
        hist_wdata = pos;
        dbuf_we = 1'b1;
        dbuf_wsel = ~src_r;
        dbuf_waddr = pos[AW-1:0];
        dbuf_wdata = val_r;
        if (i_r == '0) begin
          src_nxt = ~src_r;
          shift_nxt = shift_r + SW'(bits_eff);
          state_nxt = ST_CHECK;
        end else begin
          i_nxt = i_r - CW'(1);
          state_nxt = ST_SRD;
        end
      end
      ST_ORD: begin
        state_nxt = ST_OLD;
      end
      ST_OLD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt = dbuf_q;
        out_last_nxt = (i_r == cnt_m1);
        state_nxt = ST_OWT;
      end
      ST_OWT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt = '0;
            max_nxt = '0;
            shift_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt = i_r + CW'(1);
            state_nxt = ST_ORD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      dbits_r     <= DIGIT_BITS_RST;
      cnt_r       <= '0;
      max_r       <= '0;
      shift_r     <= '0;
      src_r       <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dbits_r     <= dbits_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      shift_r     <= shift_nxt;
      src_r       <= src_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    hidx_r     <= hidx_nxt;
    pidx_r     <= pidx_nxt;
    acc_r      <= acc_nxt;
    digit_r    <= digit_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (dbuf_we && !dbuf_wsel) begin
      dbuf_a[dbuf_waddr] <= dbuf_wdata;
    end
    dbuf_a_q <= dbuf_a[dbuf_raddr];
  end

  always_ff @(posedge clk) begin
    if (dbuf_we && dbuf_wsel) begin
      dbuf_b[dbuf_waddr] <= dbuf_wdata;
    end
    dbuf_b_q <= dbuf_b[dbuf_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[hist_waddr] <= hist_wdata;
    end
    hist_q <= hist[hist_raddr];
  end

endmodule : lsd_radix_sort_engine_top

`default_nettype wire

>>> design/lsdrs_checker.sv
// ----------------------------------------------------------------------------
// lsdrs_checker
// Port-level checks for the LSD radix sort engine, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_checker #(
  parameter int VALUE_BITS = 31,
  localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               in_tlast,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata,
  input wire logic               out_tlast
);

  logic [TDATA_W-1:0] prev_r;
  logic               have_r;
  logic               out_acc;

  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (out_acc) begin
      have_r <= !out_tlast;
    end
    if (out_acc) begin
      prev_r <= out_tdata;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a sorted word is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tlast)))
    else $error("stalled output word changed");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && have_r) |-> (out_tdata >= prev_r))
    else $error("sorted run out of order");

  a_close_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still open after last word");

  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("input not reopened after sorted run");

endmodule : lsdrs_checker

bind lsd_radix_sort_engine_top lsdrs_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_lsdrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
